FILE: src/scf_pkg.sv
// Shared constants, codes and command/status types of the shifted Cholesky block.
package scf_pkg;

   localparam int MAX_DIM_DEF   = 64;
   localparam int FRAC_BITS_DEF = 24;

   localparam int DATA_W    = 32;
   localparam int ACC_W     = 64;
   localparam int KIND_W    = 2;
   localparam int IDX_W     = 6;
   localparam int SIZE_W    = 7;
   localparam int SHIFT_W   = 31;
   localparam int CSR_IDX_W = 1;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_START = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIAG_SHIFT  = 1'd1;

   localparam logic [SIZE_W-1:0]  MATRIX_SIZE_RST = 7'd64;
   localparam logic [SHIFT_W-1:0] DIAG_SHIFT_RST  = 31'd8388608;

   typedef struct packed {
      logic in_wr;     // write K element from the request
      logic run_clr;   // new factorization: drop U rows, clear error, latch n
      logic f_rd;      // read U at both ports
      logic k_rd;      // read K[i][j]
      logic mul_go;    // register product of U reads
      logic acc_clr;
      logic acc_add;
      logic arg_go;    // form pivot argument
      logic sqrt_go;
      logic div_go;
      logic piv_wr;    // write pivot U[j][j]
      logic div_wr;    // write U[j][i]
      logic set_err;
      logic out_load;
      logic out_stat;  // status-only result
      logic out_last;
      logic rd_oob;    // requested row lies outside the array
   } cmd_type;

   typedef struct packed {
      logic arg_pos;
      logic sqrt_done;
      logic div_done;
      logic rsp_free;
   } sts_type;

endpackage

FILE: src/scf_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module scf_sqrt import scf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int SQ_W = ((DATA_W + FRAC_BITS + 1) / 2) * 2,
   localparam int RW   = SQ_W / 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [SQ_W-1:0] x,
   output logic          done,
   output logic [RW-1:0] root
);

   localparam int RMW = RW + 2;
   localparam int CW  = $clog2(RW + 1);

   logic            busy_ff;
   logic [CW-1:0]   cnt_ff;
   logic [SQ_W-1:0] x_ff;
   logic [RMW-1:0]  rem_ff;
   logic [RW-1:0]   root_ff;
   logic [RMW+1:0]  trial_rem;
   logic [RMW+1:0]  trial;
   logic            fits;

   assign trial_rem = {rem_ff, x_ff[SQ_W-1 -: 2]};
   assign trial     = (RMW + 2)'({root_ff, 2'b01});
   assign fits      = (trial_rem >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == CW'(1)) begin
         busy_ff <= 1'b0;
      end
      if (start) begin
         x_ff    <= x;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= CW'(RW);
      end else if (busy_ff) begin
         x_ff    <= x_ff << 2;
         rem_ff  <= fits ? RMW'(trial_rem - trial) : RMW'(trial_rem);
         root_ff <= {root_ff[RW-2:0], fits};
         cnt_ff  <= cnt_ff - CW'(1);
      end
   end

   assign done = !busy_ff;
   assign root = root_ff;

endmodule

FILE: src/scf_div.sv
// Iterative fixed-point divider, one quotient bit per cycle, saturating to 32 bits.
module scf_div import scf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [ACC_W-1:0]  num,
   input  logic [DATA_W-1:0]        den,
   output logic                     done,
   output logic signed [DATA_W-1:0] q
);

   localparam int QW = DATA_W - 1;
   localparam int SH = QW - FRAC_BITS;
   localparam int CW = $clog2(QW + 1);
   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {QW{1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {QW{1'b0}}};

   typedef enum logic [1:0] {D_IDLE, D_PREP, D_RUN} dstate_type;

   dstate_type        st_ff;
   logic              neg_ff;
   logic              ovf_ff;
   logic [ACC_W-1:0]  mag_ff;
   logic [DATA_W-1:0] den_ff;
   logic [DATA_W-1:0] rem_ff;
   logic [QW-1:0]     low_ff;
   logic [QW-1:0]     q_ff;
   logic [CW-1:0]     cnt_ff;
   logic [ACC_W-1:0]  hi;
   logic [DATA_W:0]   step_rem;
   logic              fits;

   assign hi       = mag_ff >> SH;
   assign step_rem = {rem_ff, low_ff[QW-1]};
   assign fits     = (step_rem >= (DATA_W + 1)'(den_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= D_IDLE;
      end else begin
         unique case (st_ff)
            D_IDLE: begin
               if (start) begin
                  st_ff <= D_PREP;
               end
            end
            D_PREP: begin
               st_ff <= (hi >= ACC_W'(den_ff)) ? D_IDLE : D_RUN;
            end
            D_RUN: begin
               if (cnt_ff == CW'(1)) begin
                  st_ff <= D_IDLE;
               end
            end
         endcase
      end
      if (start) begin
         neg_ff <= num[ACC_W-1];
         mag_ff <= num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
         den_ff <= den;
      end
      if (st_ff == D_PREP) begin
         ovf_ff <= (hi >= ACC_W'(den_ff));
         rem_ff <= DATA_W'(hi);
         low_ff <= QW'(mag_ff << FRAC_BITS);
         cnt_ff <= CW'(QW);
      end else if (st_ff == D_RUN) begin
         rem_ff <= fits ? DATA_W'(step_rem - (DATA_W + 1)'(den_ff)) : DATA_W'(step_rem);
         low_ff <= low_ff << 1;
         q_ff   <= {q_ff[QW-2:0], fits};
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   assign done = (st_ff == D_IDLE);

   always_comb begin
      if (ovf_ff) begin
         q = neg_ff ? SAT_MIN : SAT_MAX;
      end else begin
         q = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
      end
   end

endmodule

FILE: src/scf_dp.sv
// Datapath: K and U memories, multiply-accumulate, sqrt and divide units, result register.
module scf_dp import scf_pkg::*; #(
   parameter int MAX_DIM   = MAX_DIM_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int AW = $clog2(MAX_DIM),
   localparam int NW = $clog2(MAX_DIM + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [SHIFT_W-1:0]       csr_wdata,
   input  logic [IDX_W-1:0]         req_row,
   input  logic [IDX_W-1:0]         req_col,
   input  logic signed [DATA_W-1:0] req_elem_value,
   input  cmd_type                  cmd,
   input  logic [AW-1:0]            idx_j,
   input  logic [AW-1:0]            idx_i,
   input  logic [AW-1:0]            idx_k,
   input  logic [NW-1:0]            n_eff,
   output sts_type                  sts,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic [IDX_W-1:0]         rsp_out_col,
   output logic signed [DATA_W-1:0] rsp_out_value,
   output logic                     rsp_status,
   output logic                     rsp_last
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int MW    = $clog2(DEPTH);
   localparam int SQ_W  = ((DATA_W + FRAC_BITS + 1) / 2) * 2;
   localparam int RW    = SQ_W / 2;

   logic signed [DATA_W-1:0] k_mem [DEPTH];
   logic signed [DATA_W-1:0] f_mem [DEPTH];

   logic [SHIFT_W-1:0]       shift_ff;
   logic [NW-1:0]            run_n_ff;
   logic                     err_ff;
   logic [MAX_DIM-1:0]       row_valid_ff;
   logic signed [DATA_W-1:0] k_q_ff;
   logic signed [DATA_W-1:0] a_q_ff;
   logic signed [DATA_W-1:0] b_q_ff;
   logic                     ok_ff;
   logic signed [ACC_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  arg_ff;
   logic [DATA_W-1:0]        piv_ff;
   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         col_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic                     status_ff;
   logic                     last_ff;

   logic [MW-1:0]            in_addr;
   logic [MW-1:0]            a_addr;
   logic [MW-1:0]            b_addr;
   logic [MW-1:0]            k_addr;
   logic [MW-1:0]            w_addr;
   logic                     rd_ok;
   logic signed [DATA_W-1:0] w_data;
   logic                     sqrt_done;
   logic [RW-1:0]            root;
   logic                     div_done;
   logic signed [DATA_W-1:0] div_q;

   assign in_addr = MW'(int'(req_row) * MAX_DIM + int'(req_col));
   assign a_addr  = MW'(int'(idx_k) * MAX_DIM + int'(idx_i));
   assign b_addr  = MW'(int'(idx_k) * MAX_DIM + int'(idx_j));
   assign k_addr  = MW'(int'(idx_i) * MAX_DIM + int'(idx_j));
   assign w_addr  = MW'(int'(idx_j) * MAX_DIM + int'(idx_i));

   // An entry of U is live only in a finished row, on or above the diagonal, inside n.
   assign rd_ok = !cmd.rd_oob && row_valid_ff[idx_k] && (idx_i >= idx_k)
                  && (NW'(idx_i) < run_n_ff);

   assign w_data = cmd.piv_wr ? $signed(DATA_W'(root)) : div_q;

   always_ff @(posedge clock) begin
      if (cmd.in_wr) begin
         k_mem[in_addr] <= req_elem_value;
      end
      if (cmd.k_rd) begin
         k_q_ff <= k_mem[k_addr];
      end
      if (cmd.piv_wr || cmd.div_wr) begin
         f_mem[w_addr] <= w_data;
      end
      if (cmd.f_rd) begin
         a_q_ff <= f_mem[a_addr];
         b_q_ff <= f_mem[b_addr];
         ok_ff  <= rd_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= DIAG_SHIFT_RST;
         err_ff       <= 1'b0;
         row_valid_ff <= '0;
         run_n_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_DIAG_SHIFT) begin
            shift_ff <= csr_wdata;
         end
         if (cmd.run_clr) begin
            err_ff       <= 1'b0;
            row_valid_ff <= '0;
            run_n_ff     <= n_eff;
         end else begin
            if (cmd.set_err) begin
               err_ff <= 1'b1;
            end
            if (cmd.piv_wr) begin
               row_valid_ff[idx_j] <= 1'b1;
            end
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.mul_go) begin
         prod_ff <= a_q_ff * b_q_ff;
      end
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + (prod_ff >>> FRAC_BITS);
      end
      if (cmd.arg_go) begin
         arg_ff <= ACC_W'(k_q_ff) + ACC_W'(shift_ff) - acc_ff;
      end
      if (cmd.piv_wr) begin
         piv_ff <= DATA_W'(root);
      end
      if (cmd.out_load) begin
         col_ff    <= cmd.out_stat ? '0 : IDX_W'(idx_i);
         value_ff  <= (cmd.out_stat || !ok_ff) ? '0 : a_q_ff;
         status_ff <= err_ff;
         last_ff   <= cmd.out_last;
      end
   end

   // Root of a positive argument below 2^32 scaled by 2^FRAC_BITS stays under 2^31.
   scf_sqrt #(
      .FRAC_BITS (FRAC_BITS)
   ) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_go),
      .x     (SQ_W'({arg_ff[DATA_W-1:0], {FRAC_BITS{1'b0}}})),
      .done  (sqrt_done),
      .root  (root)
   );

   scf_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_go),
      .num   (ACC_W'(k_q_ff) - acc_ff),
      .den   (piv_ff),
      .done  (div_done),
      .q     (div_q)
   );

   assign sts.arg_pos   = (arg_ff > 0);
   assign sts.sqrt_done = sqrt_done;
   assign sts.div_done  = div_done;
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_col   = col_ff;
   assign rsp_out_value = value_ff;
   assign rsp_status    = status_ff;
   assign rsp_last      = last_ff;

endmodule

FILE: src/scf_ctrl.sv
// Controller: request decode and the column-order factorization sequencer.
module scf_ctrl import scf_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF,
   localparam int AW = $clog2(MAX_DIM),
   localparam int NW = $clog2(MAX_DIM + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SHIFT_W-1:0]   csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [IDX_W-1:0]     req_row,
   input  logic [IDX_W-1:0]     req_col,
   input  sts_type              sts,
   output cmd_type              cmd,
   output logic [AW-1:0]        idx_j,
   output logic [AW-1:0]        idx_i,
   output logic [AW-1:0]        idx_k,
   output logic [NW-1:0]        n_eff
);

   typedef enum logic [3:0] {
      S_IDLE, S_COL, S_SUM, S_MUL, S_ACC, S_KRD, S_KWAIT, S_ARG,
      S_SQRT, S_DIV, S_RISSUE, S_RLOAD, S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] size_ff;
   logic [NW-1:0]     j_ff, j_in;
   logic [NW-1:0]     i_ff, i_in;
   logic [NW-1:0]     k_ff, k_in;
   logic              oob_ff, oob_in;
   logic [NW-1:0]     i_nx;
   logic [NW-1:0]     j_nx;
   logic              in_ok;

   assign n_eff = (int'(size_ff) > MAX_DIM) ? NW'(MAX_DIM) : NW'(size_ff);
   assign i_nx  = i_ff + NW'(1);
   assign j_nx  = j_ff + NW'(1);
   assign in_ok = (int'(req_row) < MAX_DIM) && (int'(req_col) < MAX_DIM);

   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      i_in     = i_ff;
      k_in     = k_ff;
      oob_in   = oob_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  KIND_WRITE: begin
                     cmd.in_wr = in_ok;
                  end
                  KIND_START: begin
                     cmd.run_clr = 1'b1;
                     j_in        = '0;
                     state_in    = (n_eff == '0) ? S_DONE : S_COL;
                  end
                  KIND_READ: begin
                     k_in     = NW'(req_row);
                     oob_in   = (int'(req_row) >= MAX_DIM);
                     i_in     = '0;
                     state_in = (n_eff == '0) ? S_DONE : S_RISSUE;
                  end
                  default: begin
                     // drop unused kind
                  end
               endcase
            end
         end
         S_COL: begin
            i_in        = j_ff;
            k_in        = '0;
            cmd.acc_clr = 1'b1;
            state_in    = S_SUM;
         end
         S_SUM: begin
            if (k_ff == j_ff) begin
               state_in = S_KRD;
            end else begin
               cmd.f_rd = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_go = 1'b1;
            state_in   = S_ACC;
         end
         S_ACC: begin
            cmd.acc_add = 1'b1;
            k_in        = k_ff + NW'(1);
            state_in    = S_SUM;
         end
         S_KRD: begin
            cmd.k_rd = 1'b1;
            state_in = S_KWAIT;
         end
         S_KWAIT: begin
            if (i_ff == j_ff) begin
               cmd.arg_go = 1'b1;
               state_in   = S_ARG;
            end else begin
               cmd.div_go = 1'b1;
               state_in   = S_DIV;
            end
         end
         S_ARG: begin
            if (!sts.arg_pos) begin
               cmd.set_err = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.sqrt_go = 1'b1;
               state_in    = S_SQRT;
            end
         end
         S_SQRT, S_DIV: begin
            if ((state_ff == S_SQRT) ? sts.sqrt_done : sts.div_done) begin
               cmd.piv_wr = (state_ff == S_SQRT);
               cmd.div_wr = (state_ff == S_DIV);
               if (i_nx >= n_eff) begin
                  j_in     = j_nx;
                  state_in = (j_nx >= n_eff) ? S_DONE : S_COL;
               end else begin
                  i_in        = i_nx;
                  k_in        = '0;
                  cmd.acc_clr = 1'b1;
                  state_in    = S_SUM;
               end
            end
         end
         S_RISSUE: begin
            cmd.f_rd   = 1'b1;
            cmd.rd_oob = oob_ff;
            state_in   = S_RLOAD;
         end
         S_RLOAD: begin
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = (i_nx == n_eff);
               if (i_nx == n_eff) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_nx;
                  state_in = S_RISSUE;
               end
            end
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               cmd.out_stat = 1'b1;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         size_ff  <= MATRIX_SIZE_RST;
      end else begin
         state_ff <= state_in;
         if (csr_we && csr_index == CSR_MATRIX_SIZE) begin
            size_ff <= csr_wdata[SIZE_W-1:0];
         end
      end
      j_ff   <= j_in;
      i_ff   <= i_in;
      k_ff   <= k_in;
      oob_ff <= oob_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign idx_j     = j_ff[AW-1:0];
   assign idx_i     = i_ff[AW-1:0];
   assign idx_k     = k_ff[AW-1:0];

endmodule

FILE: src/shifted_cholesky_factorization.sv
// An element write leaves the block idle; a row read steps through S_RISSUE, reading the
// registered U memory read port, and S_RLOAD, loading the result register, per element, waiting
// in S_RLOAD while the response is held. A start transaction takes each inner-product term
// through S_SUM, S_MUL and S_ACC on the shared multiplier, then the sqrt or divide unit.
// One transaction is worked at a time. Reset is synchronous: it clears control state and the
// pivot error, and marks all U rows stale so U reads back as zero; K is undefined until written.
module shifted_cholesky_factorization import scf_pkg::*; #(
   parameter int MAX_DIM   = MAX_DIM_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // configuration writes
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [SHIFT_W-1:0]       csr_wdata,
   // request transactions
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic [IDX_W-1:0]         req_row,
   input  logic [IDX_W-1:0]         req_col,
   input  logic signed [DATA_W-1:0] req_elem_value,
   // response transactions
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [IDX_W-1:0]         rsp_out_col,
   output logic signed [DATA_W-1:0] rsp_out_value,
   output logic                     rsp_status,
   output logic                     rsp_last
);

   localparam int AW = $clog2(MAX_DIM);
   localparam int NW = $clog2(MAX_DIM + 1);

   cmd_type       cmd;
   sts_type       sts;
   logic [AW-1:0] idx_j;
   logic [AW-1:0] idx_i;
   logic [AW-1:0] idx_k;
   logic [NW-1:0] n_eff;

   // Sequencer: decodes each request transaction and walks columns j, rows i and terms k.
   scf_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .req_row   (req_row),
      .req_col   (req_col),
      .sts       (sts),
      .cmd       (cmd),
      .idx_j     (idx_j),
      .idx_i     (idx_i),
      .idx_k     (idx_k),
      .n_eff     (n_eff)
   );

   // Storage and arithmetic; the response register decouples the output side, so a write
   // transaction can be taken while a finished response still waits.
   scf_dp #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_elem_value (req_elem_value),
      .cmd            (cmd),
      .idx_j          (idx_j),
      .idx_i          (idx_i),
      .idx_k          (idx_k),
      .n_eff          (n_eff),
      .sts            (sts),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_value  (rsp_out_value),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

FILE: src/scf_checker.sv
// Port-level checks of the shifted Cholesky block and their binding to the top level.
module scf_checker import scf_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic [KIND_W-1:0]        req_kind,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [IDX_W-1:0]         rsp_out_col,
   input logic signed [DATA_W-1:0] rsp_out_value,
   input logic                     rsp_status,
   input logic                     rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_col)
         && $stable(rsp_out_value) && $stable(rsp_status) && $stable(rsp_last))
      else $error("response changed while stalled");

   a_write_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == KIND_WRITE |=> !req_stall)
      else $error("element write did not return to ready");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == KIND_WRITE && !rsp_valid |=> !rsp_valid)
      else $error("element write produced a response");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == KIND_START |=> req_stall)
      else $error("start did not hold off requests");

   a_stream_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("request taken in the middle of a row read");

endmodule

bind shifted_cholesky_factorization scf_checker u_scf_checker (.*);

FILE: bench/shifted_cholesky_factorization_tb.sv
// Self-checking bench for the shifted Cholesky block: matrix load, factor and row readback.
`timescale 1ns / 1ps

module shifted_cholesky_factorization_tb;
   import scf_pkg::*;

   localparam int DIM        = MAX_DIM_DEF;
   localparam int FRAC       = FRAC_BITS_DEF;
   localparam int WDOG_LIMIT = 400000;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct {
      logic [IDX_W-1:0]  col;
      logic [DATA_W-1:0] value;
      logic              status;
      logic              last;
   } u_entry_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [SHIFT_W-1:0]       csr_wdata;
   logic                     req_valid;
   logic                     req_stall;
   logic [KIND_W-1:0]        req_kind;
   logic [IDX_W-1:0]         req_row;
   logic [IDX_W-1:0]         req_col;
   logic signed [DATA_W-1:0] req_elem_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [IDX_W-1:0]         rsp_out_col;
   logic signed [DATA_W-1:0] rsp_out_value;
   logic                     rsp_status;
   logic                     rsp_last;

   // predictor state
   int             k_mat [DIM*DIM];
   int             u_mat [DIM*DIM];
   bit             k_written [DIM*DIM];
   bit             pivot_bad;
   bit [SIZE_W-1:0]  size_reg;
   bit [SHIFT_W-1:0] shift_reg;
   u_entry_type    u_rows_q[$];

   // run bookkeeping
   int send_idle;
   int recv_idle;
   int n_items;
   int n_results;
   int n_factors;
   int n_bad_pivots;
   int n_errors;
   int quiet_cycles;

   shifted_cholesky_factorization dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------- predictor ----------------

   function automatic int order_n();
      return (size_reg > DIM) ? DIM : int'(size_reg);
   endfunction

   // product shifted down with rounding toward minus infinity
   function automatic longint mul_floor(int a, int b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> FRAC;
   endfunction

   function automatic bit [63:0] int_root(bit [63:0] x);
      bit [63:0] r;
      bit [63:0] b;
      r = 0;
      b = 64'h1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // fixed-point divide by a positive pivot, truncating and saturating
   function automatic int pivot_divide(longint num, int d);
      bit        neg;
      bit [63:0] mag;
      bit [63:0] ud;
      bit [63:0] ip;
      bit [63:0] rem;
      bit [63:0] q;
      neg = num < 0;
      mag = neg ? 64'(-num) : 64'(num);
      ud  = 64'(d);
      ip  = mag / ud;
      rem = mag % ud;
      if ((ip >> (32 - FRAC)) != 0) q = 64'h1 << 32;
      else q = (ip << FRAC) + ((rem << FRAC) / ud);
      if (!neg) return (q > 64'h7fffffff) ? 32'h7fffffff : int'(q);
      if (q >= 64'h80000000) return 32'h80000000;
      return -int'(q);
   endfunction

   function automatic void factor_matrix();
      int        n;
      longint    acc;
      longint    arg;
      bit [63:0] r;
      int        piv;
      n = order_n();
      foreach (u_mat[x]) u_mat[x] = 0;
      pivot_bad = 1'b0;
      for (int j = 0; j < n; j++) begin
         acc = 0;
         for (int k = 0; k < j; k++) acc += mul_floor(u_mat[k*DIM+j], u_mat[k*DIM+j]);
         arg = longint'(k_mat[j*DIM+j]) + longint'(shift_reg) - acc;
         if (arg <= 0) begin
            pivot_bad = 1'b1;
            return;
         end
         r = int_root(64'(arg) << FRAC);
         piv = (r > 64'h7fffffff) ? 32'h7fffffff : int'(r);
         u_mat[j*DIM+j] = piv;
         for (int i = j + 1; i < n; i++) begin
            acc = 0;
            for (int k = 0; k < j; k++) acc += mul_floor(u_mat[k*DIM+i], u_mat[k*DIM+j]);
            u_mat[j*DIM+i] = pivot_divide(longint'(k_mat[i*DIM+j]) - acc, piv);
         end
      end
   endfunction

   function automatic void push_entry(int c, int v, bit lst);
      u_entry_type e;
      e.col    = IDX_W'(c);
      e.value  = v;
      e.status = pivot_bad;
      e.last   = lst;
      u_rows_q.push_back(e);
   endfunction

   // update the model for one accepted transaction and queue its results
   function automatic void predict(logic [KIND_W-1:0] kind, int row, int col, int value);
      int n;
      case (kind)
         KIND_WRITE: begin
            k_mat[row*DIM+col]     = value;
            k_written[row*DIM+col] = 1'b1;
         end
         KIND_START: begin
            factor_matrix();
            n_factors++;
            if (pivot_bad) n_bad_pivots++;
            push_entry(0, 0, 1'b1);
         end
         KIND_READ: begin
            n = order_n();
            if (n == 0) push_entry(0, 0, 1'b1);
            for (int c = 0; c < n; c++) push_entry(c, u_mat[row*DIM+c], c == n - 1);
         end
         default: ;
      endcase
   endfunction

   // ---------------- drivers ----------------

   // Drive one transaction at the falling edge and hold it until accepted.
   task automatic send(logic [KIND_W-1:0] kind, int row, int col = 0, int value = 0);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_row        <= IDX_W'(row);
      req_col        <= IDX_W'(col);
      req_elem_value <= value;
      do @(posedge clock); while (req_stall);
      // the block sees only the low index bits
      predict(kind, int'(IDX_W'(row)), int'(IDX_W'(col)), value);
      if (kind != KIND_UNUSED) n_items++;
   endtask

   // Drop valid and hold off until every queued result has arrived, then let
   // the block settle so a register write never lands mid-transaction.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (u_rows_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic cfg_write(logic [CSR_IDX_W-1:0] idx, int unsigned data);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= SHIFT_W'(data);
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_MATRIX_SIZE) size_reg = SIZE_W'(data);
      else shift_reg = SHIFT_W'(data);
   endtask

   // ---------------- checking ----------------

   task automatic report(string what, longint want, longint got);
      $display("tb: mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
      n_errors++;
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_idle);

   always @(posedge clock) begin
      u_entry_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (u_rows_q.size() == 0) begin
            report("unexpected result", 0, rsp_out_value);
         end else begin
            e = u_rows_q.pop_front();
            if (rsp_out_col !== e.col) report("out_col", e.col, rsp_out_col);
            if (rsp_out_value !== e.value) report("out_value", e.value, rsp_out_value);
            if (rsp_status !== e.status) report("status", e.status, rsp_status);
            if (rsp_last !== e.last) report("last", e.last, rsp_last);
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WDOG_LIMIT) begin
            $display("tb: timeout with %0d results outstanding", u_rows_q.size());
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ---------------- tests ----------------

   // Read back after reset: rows 0 and 63 of U must be all zero with the default order of 64;
   // an unused kind must produce nothing.
   task automatic test_reset_state();
      send(KIND_UNUSED, 5, 7, 32'h1234);
      send(KIND_READ, 0);
      send(KIND_READ, 63);
   endtask

   // Field extremes: saturating square root argument, saturating divides in
   // both directions, and a negative pivot on the diagonal.
   task automatic test_extremes();
      cfg_write(CSR_MATRIX_SIZE, 1);
      cfg_write(CSR_DIAG_SHIFT, 32'h7fffffff);
      send(KIND_WRITE, 0, 0, 32'h7fffffff);
      send(KIND_START, 0);
      send(KIND_READ, 0);
      cfg_write(CSR_DIAG_SHIFT, 0);
      cfg_write(CSR_MATRIX_SIZE, 2);
      send(KIND_WRITE, 0, 0, 1);
      send(KIND_WRITE, 1, 0, 32'h7fffffff);
      send(KIND_WRITE, 1, 1, 32'h7fffffff);
      send(KIND_START, 0);
      send(KIND_READ, 0);
      send(KIND_READ, 1);
      send(KIND_WRITE, 1, 0, 32'h80000000);
      send(KIND_START, 0);
      send(KIND_READ, 0);
      send(KIND_WRITE, 0, 0, 32'h80000000);
      send(KIND_START, 0);
      send(KIND_READ, 1);
   endtask

   // Order 0 (empty), order 64 and an out-of-range order that clamps to 64;
   // the large orders fail on the first pivot so they stay cheap.
   task automatic test_order_edges();
      cfg_write(CSR_MATRIX_SIZE, 0);
      send(KIND_START, 0);
      send(KIND_READ, 3);
      cfg_write(CSR_MATRIX_SIZE, 64);
      send(KIND_START, 0);
      send(KIND_READ, 63);
      cfg_write(CSR_MATRIX_SIZE, 127);
      send(KIND_WRITE, 63, 63, 32'h5a5a5a5a);
      send(KIND_START, 0);
      send(KIND_READ, 62);
   endtask

   function automatic bit lower_loaded(int n);
      for (int i = 0; i < n; i++)
         for (int j = 0; j <= i; j++)
            if (!k_written[i*DIM+j]) return 1'b0;
      return 1'b1;
   endfunction

   // One load / factor / readback sequence with random content.
   task automatic run_sequence();
      int n;
      bit wild;
      int v;
      n = ($urandom_range(9) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
      cfg_write(CSR_MATRIX_SIZE, n);
      case ($urandom_range(5))
         0: cfg_write(CSR_DIAG_SHIFT, 0);
         1: cfg_write(CSR_DIAG_SHIFT, 32'h7fffffff);
         2: cfg_write(CSR_DIAG_SHIFT, $urandom_range(0, 32'h7fffffff));
         3: cfg_write(CSR_DIAG_SHIFT, $urandom_range(0, 1 << 25));
         default: ;
      endcase
      wild = ($urandom_range(4) == 0);
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j <= i; j++) begin
            if (wild) v = $urandom;
            else if (i == j) v = $urandom_range((n + 1) << 24, (n + 4) << 24);
            else v = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
            send(KIND_WRITE, i, j, v);
            // sprinkle noise: stray writes and unused kinds
            if ($urandom_range(15) == 0) send(KIND_UNUSED, $urandom, $urandom, $urandom);
            if ($urandom_range(15) == 0) send(KIND_WRITE, $urandom, $urandom, $urandom);
         end
      end
      if (lower_loaded(n)) send(KIND_START, 0);
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(4) == 0) send(KIND_READ, $urandom_range(0, 63));
         else send(KIND_READ, $urandom_range(0, n - 1));
      end
   endtask

   task automatic test_random();
      int target;
      int base;
      base = n_items;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle = 34; recv_idle = 61; end
            1: begin send_idle = 61; recv_idle = 34; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         target = base + 160 * (phase + 1);
         while (n_items < target) run_sequence();
      end
   endtask

   initial begin
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= CSR_MATRIX_SIZE;
      csr_wdata      <= '0;
      req_valid      <= 1'b0;
      req_kind       <= KIND_WRITE;
      req_row        <= '0;
      req_col        <= '0;
      req_elem_value <= '0;
      rsp_stall      <= 1'b0;
      send_idle    = 20;
      recv_idle    = 20;
      n_items      = 0;
      n_results    = 0;
      n_factors    = 0;
      n_bad_pivots = 0;
      n_errors     = 0;
      quiet_cycles = 0;
      pivot_bad    = 1'b0;
      size_reg     = MATRIX_SIZE_RST;
      shift_reg    = DIAG_SHIFT_RST;
      foreach (u_mat[x]) begin
         u_mat[x]     = 0;
         k_mat[x]     = 0;
         k_written[x] = 1'b0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_extremes();
      test_order_edges();
      test_random();

      drain();
      repeat (100) @(posedge clock);
      $display("tb: %0d transactions sent, %0d results checked", n_items, n_results);
      $display("tb: %0d factorizations, %0d stopped on a bad pivot, %0d mismatches",
               n_factors, n_bad_pivots, n_errors);
      if (n_errors == 0 && u_rows_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
